>>> hw/rtl/exif_pkg.sv
// Shared types and constants for the EXIF orientation extractor.
// Used by the parse sequencer and the top level; depends on nothing.
package exif_pkg;

  typedef enum logic [3:0] {
    ST_FOUND         = 4'd0,
    ST_SHORT         = 4'd1,
    ST_SIGNATURE     = 4'd2,
    ST_BYTE_ORDER    = 4'd3,
    ST_MAGIC         = 4'd4,
    ST_IFD_RANGE     = 4'd5,
    ST_ENTRIES_RANGE = 4'd6,
    ST_TYPE_COUNT    = 4'd7,
    ST_VALUE_RANGE   = 4'd8,
    ST_ABSENT        = 4'd9,
    ST_OVERFLOW      = 4'd10
  } exif_status_e;

  typedef struct packed {
    logic [3:0]   orientation;
    exif_status_e status;
  } exif_result_t;

  localparam int unsigned SigBytes   = 6;
  localparam int unsigned MinBytes   = 14;
  localparam int unsigned EntryBytes = 12;

  localparam logic [31:0] SIG_HEAD   = 32'h4578_6966;
  localparam logic [15:0] SIG_TAIL   = 16'h0000;
  localparam logic [15:0] BOM_LITTLE = 16'h4949;
  localparam logic [15:0] BOM_BIG    = 16'h4D4D;
  localparam logic [15:0] TIFF_MAGIC = 16'd42;
  localparam logic [15:0] TAG_ORIENT = 16'h0112;
  localparam logic [15:0] TYPE_SHORT = 16'd3;
  localparam logic [31:0] COUNT_ONE  = 32'd1;
  localparam logic [15:0] ORIENT_MAX = 16'd8;

endpackage

>>> hw/rtl/exif_orientation_extractor.sv
// Top level of the EXIF orientation extractor: payload buffer, collect logic,
// and the output register. Depends on exif_pkg, exif_ram and exif_parse.
//
// Payload bytes are taken one per cycle while in_ready_o is high and written into a
// BUFFER_BYTES deep RAM; bytes past its capacity are dropped and turn the result
// into an overflow status. The beat marked last starts the parse unless bytes were
// dropped, and in_ready_o is low during the parse. The parser reads the RAM one byte
// at a time, through an address state and a data state, and checks each field in a
// check state; the result goes through the parser's done and result registers and
// then the output register. A short payload takes the same path from the last beat,
// and an overflowed one is written into the output register from the last beat. One
// result beat follows every last beat; it sits in an output register, and no new
// beat is taken until that result beat is taken.
module exif_orientation_extractor import exif_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] orientation_o,
  output logic [3:0] status_o
);

  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned AW = $clog2(BUFFER_BYTES);

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          out_valid_q, out_valid_d;
  exif_result_t  out_q, out_d;

  logic          in_fire;
  logic          room;
  logic          start;
  logic [CW-1:0] start_size;
  logic          parse_rd_en;
  logic [AW-1:0] parse_rd_addr;
  logic [7:0]    ram_rd_data;
  logic          parse_busy;
  logic          parse_done;
  exif_result_t  parse_result;

  assign room       = (count_q != CW'(BUFFER_BYTES));
  assign in_ready_o = !parse_busy && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign start      = in_fire && last_byte_i && room && !ovf_q;
  assign start_size = count_q + CW'(1);

  exif_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (in_fire && room),
    .wr_addr_i(count_q[AW-1:0]),
    .wr_data_i(data_byte_i),
    .rd_en_i  (parse_rd_en),
    .rd_addr_i(parse_rd_addr),
    .rd_data_o(ram_rd_data)
  );

  exif_parse #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .size_i   (start_size),
    .rd_en_o  (parse_rd_en),
    .rd_addr_o(parse_rd_addr),
    .rd_data_i(ram_rd_data),
    .busy_o   (parse_busy),
    .done_o   (parse_done),
    .result_o (parse_result)
  );

  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (in_fire) begin
      if (last_byte_i) begin
        count_d = '0;
        ovf_d   = 1'b0;
        if (ovf_q || !room) begin
          out_valid_d = 1'b1;
          out_d       = '{orientation: 4'd0, status: ST_OVERFLOW};
        end
      end else if (room) begin
        count_d = count_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (parse_done) begin
      out_valid_d = 1'b1;
      out_d       = parse_result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign orientation_o = out_q.orientation;
  assign status_o      = out_q.status;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(BUFFER_BYTES))
    else $error("Byte count exceeds the buffer capacity.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    parse_done |=> out_valid_q)
    else $error("Parse result was not captured in the output register.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    parse_done |-> (!out_valid_q || out_ready_i))
    else $error("Parse result would overwrite an unsent result beat.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> parse_busy)
    else $error("Parser did not start on the last beat.");

endmodule

>>> hw/rtl/exif_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module exif_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/exif_parse.sv
// Parse sequencer: reads the stored payload one byte at a time through the RAM
// read port and checks the TIFF header and IFD0 entries. Depends on exif_pkg.
module exif_parse import exif_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [$clog2(BUFFER_BYTES+1)-1:0] size_i,
  output logic                              rd_en_o,
  output logic [$clog2(BUFFER_BYTES)-1:0]   rd_addr_o,
  input  logic [7:0]                        rd_data_i,
  output logic                              busy_o,
  output logic                              done_o,
  output exif_result_t                      result_o
);

  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned SW = ((CW > 20) ? CW : 20) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_ADDR,
    S_RD_DATA,
    S_CHECK,
    S_ENTRY
  } state_e;

  typedef enum logic [3:0] {
    PH_SIG_HEAD,
    PH_SIG_TAIL,
    PH_BOM,
    PH_MAGIC,
    PH_IFD,
    PH_COUNT,
    PH_TAG,
    PH_TYPE,
    PH_CNT,
    PH_VALUE
  } phase_e;

  state_e       state_q, state_d;
  phase_e       phase_q, phase_d;
  logic [CW-1:0] size_q, size_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [31:0]  acc_q, acc_d;
  logic [1:0]   k_q, k_d;
  logic [1:0]   last_k_q, last_k_d;
  logic         little_q, little_d;
  logic         type_ok_q, type_ok_d;
  logic [15:0]  n_q, n_d;
  logic         done_q, done_d;
  exif_result_t result_q, result_d;

  logic [32:0]  ifd_end;
  logic [32:0]  tiff_bytes;
  logic [19:0]  span;
  logic [SW-1:0] ents_end;

  assign ifd_end    = {1'b0, acc_q} + 33'd2;
  assign tiff_bytes = 33'(size_q - CW'(SigBytes));
  assign span       = 20'({acc_q[15:0], 3'b000}) + 20'({acc_q[15:0], 2'b00});
  assign ents_end   = SW'(ptr_q) + SW'(span);

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    size_d    = size_q;
    ptr_d     = ptr_q;
    acc_d     = acc_q;
    k_d       = k_q;
    last_k_d  = last_k_q;
    little_d  = little_q;
    type_ok_d = type_ok_q;
    n_d       = n_q;
    done_d    = 1'b0;
    result_d  = result_q;
    rd_en_o   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          size_d   = size_i;
          little_d = 1'b0;
          if (size_i < CW'(MinBytes)) begin
            result_d = '{orientation: 4'd0, status: ST_SHORT};
            done_d   = 1'b1;
          end else begin
            ptr_d    = '0;
            acc_d    = '0;
            k_d      = '0;
            last_k_d = 2'd3;
            phase_d  = PH_SIG_HEAD;
            state_d  = S_RD_ADDR;
          end
        end
      end
      S_RD_ADDR: begin
        rd_en_o = 1'b1;
        state_d = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (little_q) begin
          acc_d = acc_q | (32'(rd_data_i) << {k_q, 3'b000});
        end else begin
          acc_d = {acc_q[23:0], rd_data_i};
        end
        ptr_d = ptr_q + CW'(1);
        k_d   = k_q + 2'd1;
        if (k_q == last_k_q) begin
          state_d = S_CHECK;
        end else begin
          state_d = S_RD_ADDR;
        end
      end
      S_CHECK: begin
        acc_d    = '0;
        k_d      = '0;
        last_k_d = 2'd1;
        state_d  = S_RD_ADDR;
        case (phase_q)
          PH_SIG_HEAD: begin
            phase_d = PH_SIG_TAIL;
            if (acc_q != SIG_HEAD) begin
              result_d = '{orientation: 4'd0, status: ST_SIGNATURE};
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end
          end
          PH_SIG_TAIL: begin
            phase_d = PH_BOM;
            if (acc_q[15:0] != SIG_TAIL) begin
              result_d = '{orientation: 4'd0, status: ST_SIGNATURE};
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end
          end
          PH_BOM: begin
            phase_d = PH_MAGIC;
            if (acc_q[15:0] == BOM_LITTLE) begin
              little_d = 1'b1;
            end else if (acc_q[15:0] != BOM_BIG) begin
              result_d = '{orientation: 4'd0, status: ST_BYTE_ORDER};
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end
          end
          PH_MAGIC: begin
            phase_d  = PH_IFD;
            last_k_d = 2'd3;
            if (acc_q[15:0] != TIFF_MAGIC) begin
              result_d = '{orientation: 4'd0, status: ST_MAGIC};
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end
          end
          PH_IFD: begin
            phase_d = PH_COUNT;
            ptr_d   = CW'(SigBytes) + acc_q[CW-1:0];
            if (ifd_end > tiff_bytes) begin
              result_d = '{orientation: 4'd0, status: ST_IFD_RANGE};
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end
          end
          PH_COUNT: begin
            n_d = acc_q[15:0];
            if (ents_end > SW'(size_q)) begin
              result_d = '{orientation: 4'd0, status: ST_ENTRIES_RANGE};
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              state_d = S_ENTRY;
            end
          end
          PH_TAG: begin
            if (acc_q[15:0] == TAG_ORIENT) begin
              phase_d = PH_TYPE;
            end else begin
              ptr_d   = ptr_q + CW'(EntryBytes - 2);
              n_d     = n_q - 16'd1;
              state_d = S_ENTRY;
            end
          end
          PH_TYPE: begin
            type_ok_d = (acc_q[15:0] == TYPE_SHORT);
            phase_d   = PH_CNT;
            last_k_d  = 2'd3;
          end
          PH_CNT: begin
            phase_d = PH_VALUE;
            if (!type_ok_q || (acc_q != COUNT_ONE)) begin
              result_d = '{orientation: 4'd0, status: ST_TYPE_COUNT};
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end
          end
          PH_VALUE: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
            if ((acc_q[15:0] == 16'd0) || (acc_q[15:0] > ORIENT_MAX)) begin
              result_d = '{orientation: 4'd0, status: ST_VALUE_RANGE};
            end else begin
              result_d = '{orientation: acc_q[3:0], status: ST_FOUND};
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_ENTRY: begin
        acc_d    = '0;
        k_d      = '0;
        last_k_d = 2'd1;
        phase_d  = PH_TAG;
        if (n_q == 16'd0) begin
          result_d = '{orientation: 4'd0, status: ST_ABSENT};
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_RD_ADDR;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_SIG_HEAD;
      done_q   <= 1'b0;
      result_q <= '{orientation: 4'd0, status: ST_FOUND};
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      done_q   <= done_d;
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q    <= size_d;
    ptr_q     <= ptr_d;
    acc_q     <= acc_d;
    k_q       <= k_d;
    last_k_q  <= last_k_d;
    little_q  <= little_d;
    type_ok_q <= type_ok_d;
    n_q       <= n_d;
  end

  assign rd_addr_o = ptr_q[AW-1:0];
  assign busy_o    = (state_q != S_IDLE) || done_q;
  assign done_o    = done_q;
  assign result_o  = result_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_DATA) |-> $past(rd_en_o))
    else $error("Read data taken without a read issued the cycle before.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_ADDR) |-> (ptr_q < size_q))
    else $error("Parse read pointer left the stored payload.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ((result_q.status == ST_FOUND) == (result_q.orientation != 4'd0)))
    else $error("Orientation and status disagree.");

endmodule

>>> tb/exif_orientation_extractor_tb.sv
// Self-checking testbench for exif_orientation_extractor: builds EXIF payloads, streams them
// in byte by byte and compares every result beat with an in-bench EXIF/TIFF header decoder.
// Depends on exif_pkg and the exif_orientation_extractor RTL.
module exif_orientation_extractor_tb;
  import exif_pkg::*;

  localparam int unsigned BufBytes = 4096;
  localparam int unsigned TiffHdrBytes = MinBytes - SigBytes;
  localparam int unsigned QuietLimit = 20000;
  localparam int unsigned DrainCycles = 100;

  typedef logic [7:0] octet_q_t[$];

  typedef struct {
    bit          little;
    int unsigned pad;
    int unsigned entries;
    logic [15:0] claim;
    int          orient_at;
    logic [15:0] otype;
    logic [31:0] ocount;
    logic [15:0] oval;
    int unsigned tail;
    logic [31:0] ifd;
  } ifd_layout_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       last_byte_i;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [3:0] orientation_o;
  logic [3:0] status_o;

  logic [7:0]   payload_mem [BufBytes];
  int unsigned  stored_bytes = 0;
  bit           bytes_dropped = 1'b0;
  exif_result_t pending_results[$];
  int unsigned  bytes_sent = 0;
  int unsigned  results_predicted = 0;
  int unsigned  fail_count = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  send_gap_pct = 0;
  int unsigned  sink_stall_pct = 0;

  exif_orientation_extractor #(
    .BUFFER_BYTES(BufBytes)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .orientation_o(orientation_o),
    .status_o     (status_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- decoder
  function automatic logic [7:0] get8(longint unsigned pos);
    return (pos >= BufBytes) ? 8'h00 : payload_mem[pos];
  endfunction

  function automatic logic [15:0] get16(longint unsigned pos, bit little);
    return little ? {get8(pos + 1), get8(pos)} : {get8(pos), get8(pos + 1)};
  endfunction

  function automatic logic [31:0] get32(longint unsigned pos, bit little);
    return little ? {get16(pos + 2, little), get16(pos, little)}
                  : {get16(pos, little), get16(pos + 2, little)};
  endfunction

  function automatic bit fits_in(longint unsigned size, longint unsigned off,
                                 longint unsigned len);
    return off <= size && len <= size - off;
  endfunction

  function automatic exif_status_e decode_orientation(output logic [3:0] orient);
    longint unsigned size, tsize, ifd, ents, pos, n, i;
    logic [15:0] v;
    bit little;
    orient = 4'd0;
    size = stored_bytes;
    if (size < MinBytes) return ST_SHORT;
    if ({get8(0), get8(1), get8(2), get8(3)} != SIG_HEAD || {get8(4), get8(5)} != SIG_TAIL)
      return ST_SIGNATURE;
    if ({get8(6), get8(7)} == BOM_LITTLE) little = 1'b1;
    else if ({get8(6), get8(7)} == BOM_BIG) little = 1'b0;
    else return ST_BYTE_ORDER;
    if (get16(8, little) != TIFF_MAGIC) return ST_MAGIC;
    tsize = size - SigBytes;
    ifd = get32(10, little);
    if (!fits_in(tsize, ifd, 2)) return ST_IFD_RANGE;
    n = get16(SigBytes + ifd, little);
    ents = ifd + 2;
    if (!fits_in(tsize, ents, n * EntryBytes)) return ST_ENTRIES_RANGE;
    for (i = 0; i < n; i++) begin
      pos = SigBytes + ents + i * EntryBytes;
      if (get16(pos, little) == TAG_ORIENT) begin
        if (get16(pos + 2, little) != TYPE_SHORT || get32(pos + 4, little) != COUNT_ONE)
          return ST_TYPE_COUNT;
        v = get16(pos + 8, little);
        if (v == 16'd0 || v > ORIENT_MAX) return ST_VALUE_RANGE;
        orient = v[3:0];
        return ST_FOUND;
      end
    end
    return ST_ABSENT;
  endfunction

  function automatic void absorb_payload_byte(logic [7:0] b, logic lst);
    exif_result_t want;
    logic [3:0] orient;
    exif_status_e st;
    bytes_sent++;
    if (stored_bytes < BufBytes) begin
      payload_mem[stored_bytes] = b;
      stored_bytes++;
    end else begin
      bytes_dropped = 1'b1;
    end
    if (lst) begin
      if (bytes_dropped) begin
        orient = 4'd0;
        st = ST_OVERFLOW;
      end else begin
        st = decode_orientation(orient);
      end
      want.orientation = orient;
      want.status = st;
      pending_results.push_back(want);
      results_predicted++;
      stored_bytes = 0;
      bytes_dropped = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------- payload builders
  function automatic void put16(ref octet_q_t q, input logic [15:0] v, input bit little);
    if (little) begin
      q.push_back(v[7:0]);
      q.push_back(v[15:8]);
    end else begin
      q.push_back(v[15:8]);
      q.push_back(v[7:0]);
    end
  endfunction

  function automatic void put32(ref octet_q_t q, input logic [31:0] v, input bit little);
    if (little) begin
      put16(q, v[15:0], little);
      put16(q, v[31:16], little);
    end else begin
      put16(q, v[31:16], little);
      put16(q, v[15:0], little);
    end
  endfunction

  function automatic void put_header(ref octet_q_t q, input bit little, input logic [31:0] ifd);
    put32(q, SIG_HEAD, 1'b0);
    put16(q, SIG_TAIL, 1'b0);
    put16(q, little ? BOM_LITTLE : BOM_BIG, 1'b0);
    put16(q, TIFF_MAGIC, little);
    put32(q, ifd, little);
  endfunction

  function automatic void put_entry(ref octet_q_t q, input logic [15:0] tag,
                                    input logic [15:0] typ, input logic [31:0] cnt,
                                    input logic [15:0] val, input bit little);
    put16(q, tag, little);
    put16(q, typ, little);
    put32(q, cnt, little);
    put16(q, val, little);
    q.push_back(8'($urandom));
    q.push_back(8'($urandom));
  endfunction

  function automatic logic [15:0] other_tag();
    logic [15:0] tag;
    do tag = 16'($urandom); while (tag == TAG_ORIENT);
    return tag;
  endfunction

  function automatic octet_q_t build_payload(ifd_layout_t s);
    octet_q_t q;
    int i;
    put_header(q, s.little, s.ifd);
    repeat (s.pad) q.push_back(8'($urandom));
    put16(q, s.claim, s.little);
    for (i = 0; i < s.entries; i++) begin
      if (i == s.orient_at) put_entry(q, TAG_ORIENT, s.otype, s.ocount, s.oval, s.little);
      else put_entry(q, other_tag(), 16'($urandom_range(12)), $urandom_range(4),
                     16'($urandom), s.little);
    end
    repeat (s.tail) q.push_back(8'($urandom));
    return q;
  endfunction

  function automatic ifd_layout_t random_spec();
    ifd_layout_t s;
    s.little = 1'($urandom_range(1));
    s.pad = $urandom_range(6);
    s.entries = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(3);
    s.claim = 16'(s.entries);
    s.orient_at = $urandom_range(s.entries);
    s.otype = TYPE_SHORT;
    s.ocount = COUNT_ONE;
    s.oval = 16'($urandom_range(1, 8));
    s.tail = $urandom_range(6);
    s.ifd = TiffHdrBytes + s.pad;
    return s;
  endfunction

  function automatic ifd_layout_t oriented_spec();
    ifd_layout_t s;
    s = random_spec();
    if (s.entries == 0) begin
      s.entries = 1;
      s.claim = 16'd1;
    end
    s.orient_at = $urandom_range(s.entries - 1);
    return s;
  endfunction

  function automatic octet_q_t random_payload();
    octet_q_t q;
    ifd_layout_t s;
    int unsigned kind, idx, len;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      len = $urandom_range(1, 24);
      repeat (len) q.push_back(8'($urandom));
      return q;
    end
    s = random_spec();
    if (kind >= 45 && kind < 60) begin
      case ($urandom_range(5))
        0: s.otype = 16'($urandom);
        1: s.ocount = $urandom_range(3);
        2: s.oval = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(15));
        3: s.claim = s.claim + 16'($urandom_range(1, 3));
        4: s.ifd = $urandom_range(1) ? $urandom : $urandom_range(40);
        default: s.orient_at = -1;
      endcase
    end
    q = build_payload(s);
    if (kind >= 60 && kind < 75) begin
      if ($urandom_range(1)) begin
        idx = $urandom_range(q.size() - 1);
        q[idx] = q[idx] ^ 8'($urandom_range(1, 255));
      end else begin
        len = $urandom_range(1, q.size());
        while (q.size() > len) void'(q.pop_back());
      end
    end else if (kind >= 75) begin
      idx = $urandom_range(MinBytes - 1);
      q[idx] = q[idx] ^ 8'($urandom_range(1, 255));
    end
    return q;
  endfunction

  // ---------------------------------------------------------------- driving
  // Entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    absorb_payload_byte(b, lst);
    @(negedge clk_i);
  endtask

  task automatic send_payload(input octet_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------- checking
  always @(posedge clk_i) begin : check_results
    exif_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: orientation %0d, status %0d", orientation_o, status_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (orientation_o !== want.orientation) begin
          $error("orientation mismatch: expected %0d, actual %0d", want.orientation,
                 orientation_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("exif_orientation_extractor verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_short_payloads();
    octet_q_t q;
    q = build_payload(random_spec());
    while (q.size() > 1) void'(q.pop_back());
    send_payload(q);
    q = build_payload(random_spec());
    while (q.size() > MinBytes - 1) void'(q.pop_back());
    send_payload(q);
    q = {};
    put_header(q, 1'b1, TiffHdrBytes);
    send_payload(q);
  endtask

  task automatic test_header_checks();
    octet_q_t q;
    ifd_layout_t s;
    s = oriented_spec();
    q = build_payload(s);
    q[0] = q[0] ^ 8'h20;
    send_payload(q);
    q = build_payload(s);
    q[5] = 8'h01;
    send_payload(q);
    q = build_payload(s);
    {q[6], q[7]} = {BOM_LITTLE[15:8], BOM_BIG[7:0]};
    send_payload(q);
    q = build_payload(s);
    {q[6], q[7]} = {BOM_BIG[15:8], BOM_LITTLE[7:0]};
    send_payload(q);
    s.little = 1'b0;
    q = build_payload(s);
    {q[8], q[9]} = {q[9], q[8]};
    send_payload(q);
    s.little = 1'b1;
    q = build_payload(s);
    q[8] = q[8] ^ 8'h01;
    send_payload(q);
  endtask

  task automatic test_ifd_bounds();
    ifd_layout_t s;
    s = oriented_spec();
    s.ifd = 32'hFFFF_FFFF;
    send_payload(build_payload(s));
    s = random_spec();
    s.entries = 0;
    s.claim = 16'd0;
    s.tail = 0;
    send_payload(build_payload(s));
    s.little = !s.little;
    s.ifd = s.ifd + 1;
    send_payload(build_payload(s));
    s = oriented_spec();
    s.tail = 0;
    s.claim = s.claim + 16'd1;
    send_payload(build_payload(s));
    s.claim = 16'hFFFF;
    send_payload(build_payload(s));
  endtask

  task automatic test_orientation_values();
    ifd_layout_t s;
    int v;
    for (v = 0; v <= 9; v++) begin
      s = oriented_spec();
      s.little = v[0];
      s.oval = 16'(v);
      send_payload(build_payload(s));
    end
    s = oriented_spec();
    s.oval = 16'hFFFF;
    send_payload(build_payload(s));
    s.oval = 16'h0100;
    send_payload(build_payload(s));
    s = oriented_spec();
    s.otype = 16'd4;
    send_payload(build_payload(s));
    s.otype = TYPE_SHORT;
    s.ocount = 32'd0;
    send_payload(build_payload(s));
    s.ocount = 32'd2;
    send_payload(build_payload(s));
    s.little = !s.little;
    s.ocount = 32'h0001_0001;
    send_payload(build_payload(s));
  endtask

  task automatic send_two_tags(input bit little, input logic [15:0] first_type,
                               input logic [15:0] first_val);
    octet_q_t q;
    put_header(q, little, TiffHdrBytes);
    put16(q, 16'd3, little);
    put_entry(q, other_tag(), TYPE_SHORT, COUNT_ONE, 16'($urandom), little);
    put_entry(q, TAG_ORIENT, first_type, COUNT_ONE, first_val, little);
    put_entry(q, TAG_ORIENT, TYPE_SHORT, COUNT_ONE, 16'($urandom_range(1, 8)), little);
    send_payload(q);
  endtask

  task automatic test_repeated_tags();
    send_two_tags(1'b1, TYPE_SHORT, 16'd5);
    send_two_tags(1'b0, 16'd4, 16'd3);
    send_two_tags(1'b1, TYPE_SHORT, 16'd0);
  endtask

  task automatic run_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct,
                                    input int unsigned byte_target,
                                    input int unsigned result_target);
    int unsigned bytes0, results0;
    send_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    bytes0 = bytes_sent;
    results0 = results_predicted;
    while (bytes_sent - bytes0 < byte_target || results_predicted - results0 < result_target)
      send_payload(random_payload());
  endtask

  task automatic test_random_back_to_back();
    run_random_traffic(0, 0, 80, 2);
  endtask

  task automatic test_random_sender_gaps();
    run_random_traffic(69, 0, 80, 2);
  endtask

  task automatic test_random_receiver_stalls();
    run_random_traffic(0, 69, 80, 2);
  endtask

  task automatic test_random_both_sides();
    run_random_traffic(14, 14, 80, 2);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = 8'h00;
    last_byte_i = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_short_payloads();
    test_header_checks();
    test_ifd_bounds();
    test_orientation_values();
    test_repeated_tags();
    test_random_back_to_back();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_sides();

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) $display("exif_orientation_extractor verification clean");
    else $display("exif_orientation_extractor verification failed");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/exif_pkg.sv
hw/rtl/exif_ram.sv
hw/rtl/exif_parse.sv
hw/rtl/exif_orientation_extractor.sv
tb/exif_orientation_extractor_tb.sv
